>>> src/bptc_pkg.sv
// Shared types and constants for the barometer compensation pipeline.
package bptc_pkg;

   // Pipeline depth, input register to output register
   localparam int NUM_STAGES = 8;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SENS_BASE,
      CSR_OFFSET_BASE,
      CSR_SENS_TEMP_COEFF,
      CSR_OFFSET_TEMP_COEFF,
      CSR_REF_TEMPERATURE_RAW,
      CSR_TEMP_SLOPE_COEFF,
      CSR_PRESSURE_BIAS,
      CSR_CURVATURE_TERMS
   } csr_index_type;

   // Load enables and valid bits, one per stage
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // Arithmetic constants
   localparam int SQ_SHIFT        = 14;
   localparam int OFF_TC_BIAS     = 1024;
   localparam int OFF_DIV_SHIFT   = 14;
   localparam int SENS_DIV_SHIFT  = 10;
   localparam int PRESS_ZERO      = 7168;
   localparam int X_DIV_SHIFT     = 14;
   localparam int PRESS_DIV_SHIFT = 5;
   localparam int TEMP_BASE       = 250;
   localparam int TEMP_DIV_SHIFT  = 16;

endpackage

>>> src/bptc_pipe_ctrl.sv
// Valid bits and per-stage load enables for the compensation pipeline.
module bptc_pipe_ctrl import bptc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          out_stall,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // A stage loads when empty or when the stage after it moves on,
   // so bubbles close up behind a stalled output.
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !out_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load  = load;
   assign ctrl.valid = valid_ff;

endmodule

>>> src/barometer_raw_to_pressure_temperature.sv
// Top level: second-order barometer compensation, raw words to 0.1 hPa and 0.1 degrees.
//
//  channel  dir  handshake           payload
//  req_     in   req_valid/req_stall  raw_pressure[15:0], raw_temperature[15:0]
//  rsp_     out  rsp_valid/rsp_stall  pressure_tenths[31:0], temperature_tenths[31:0] (signed)
//  csr_     in   csr_wr_en            csr_addr[2:0], csr_wdata[31:0]
//
// One item a cycle while rsp_ is not stalled, through eight register stages, stage 0 to
// stage 7; rsp_valid is the valid bit of stage 7, which is the output register.
// A multiplier is the deepest path in four of the stages.
// Reset clears the coefficient registers to zero and empties the pipeline.
// A stall on rsp_ holds the output register; earlier stages keep moving into
// empty slots, so req_stall rises only once every stage holds an item.
module barometer_raw_to_pressure_temperature import bptc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_raw_pressure,
   input  logic [15:0]            req_raw_temperature,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_pressure_tenths,
   output logic signed [31:0]     rsp_temperature_tenths,
   input  logic                   csr_wr_en,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Signed division by 2^sh, truncating toward zero
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                    input int sh);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (v + bias) >>> sh;
   endfunction

   // ---------------------------------------------------------------------
   // Coefficient registers
   // ---------------------------------------------------------------------
   logic [15:0] sens_base_ff;
   logic [15:0] offset_base_ff;
   logic [15:0] sens_tc_ff;
   logic [15:0] offset_tc_ff;
   logic [15:0] ref_temp_ff;
   logic [15:0] temp_slope_ff;
   logic [15:0] press_bias_ff;
   logic [31:0] curv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_base_ff   <= '0;
         offset_base_ff <= '0;
         sens_tc_ff     <= '0;
         offset_tc_ff   <= '0;
         ref_temp_ff    <= '0;
         temp_slope_ff  <= '0;
         press_bias_ff  <= '0;
         curv_ff        <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_SENS_BASE:           sens_base_ff   <= csr_wdata[15:0];
            CSR_OFFSET_BASE:         offset_base_ff <= csr_wdata[15:0];
            CSR_SENS_TEMP_COEFF:     sens_tc_ff     <= csr_wdata[15:0];
            CSR_OFFSET_TEMP_COEFF:   offset_tc_ff   <= csr_wdata[15:0];
            CSR_REF_TEMPERATURE_RAW: ref_temp_ff    <= csr_wdata[15:0];
            CSR_TEMP_SLOPE_COEFF:    temp_slope_ff  <= csr_wdata[15:0];
            CSR_PRESSURE_BIAS:       press_bias_ff  <= csr_wdata[15:0];
            CSR_CURVATURE_TERMS:     curv_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // packed curvature fields; shifts use their low nibble only
   logic [7:0] gain_above;
   logic [7:0] gain_below;
   logic [3:0] curv_shift;
   logic [3:0] temp_shift;

   assign gain_above = curv_ff[31:24];
   assign gain_below = curv_ff[23:16];
   assign curv_shift = curv_ff[11:8];
   assign temp_shift = curv_ff[3:0];

   // ---------------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------------
   pipe_ctrl_type ctrl;

   bptc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   assign req_stall = !ctrl.load[0];
   assign rsp_valid = ctrl.valid[NUM_STAGES-1];

   // ---------------------------------------------------------------------
   // Stage 0: deviation from reference reading, sign for gain choice
   // ---------------------------------------------------------------------
   logic signed [16:0] s0_dev_in;
   logic signed [16:0] s0_dev_ff;
   logic               s0_above_ff;
   logic [15:0]        s0_d1_ff;

   assign s0_dev_in = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, ref_temp_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s0_dev_ff   <= s0_dev_in;
         s0_above_ff <= (req_raw_temperature >= ref_temp_ff);
         s0_d1_ff    <= req_raw_pressure;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: square of deviation, scaled down
   // ---------------------------------------------------------------------
   logic signed [33:0] s1_sq_full;
   logic [17:0]        s1_sq_ff;
   logic signed [16:0] s1_dev_ff;
   logic [7:0]         s1_gain_ff;
   logic [15:0]        s1_d1_ff;

   // never negative and below 2^32
   assign s1_sq_full = s0_dev_ff * s0_dev_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s1_sq_ff   <= s1_sq_full[SQ_SHIFT+17:SQ_SHIFT];
         s1_dev_ff  <= s0_dev_ff;
         s1_gain_ff <= s0_above_ff ? gain_above : gain_below;
         s1_d1_ff   <= s0_d1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: curvature correction
   // ---------------------------------------------------------------------
   logic [25:0]        s2_curv_prod;
   logic [25:0]        s2_curv_term;
   logic signed [27:0] s2_dut_in;
   logic signed [27:0] s2_dut_ff;
   logic [15:0]        s2_d1_ff;

   assign s2_curv_prod = s1_sq_ff * s1_gain_ff;
   assign s2_curv_term = s2_curv_prod >> curv_shift;
   assign s2_dut_in    = 28'(s1_dev_ff) - $signed({2'b00, s2_curv_term});

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s2_dut_ff <= s2_dut_in;
         s2_d1_ff  <= s1_d1_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: the three coefficient products, dut / 2^tshift
   // ---------------------------------------------------------------------
   logic signed [16:0] s3_off_tc;
   logic signed [44:0] s3_off_prod_in;
   logic signed [44:0] s3_sens_prod_in;
   logic signed [44:0] s3_tslope_prod_in;
   logic signed [27:0] s3_dut_div_in;
   logic signed [16:0] s3_d1m_in;
   logic signed [44:0] s3_off_prod_ff;
   logic signed [44:0] s3_sens_prod_ff;
   logic signed [44:0] s3_tslope_prod_ff;
   logic signed [27:0] s3_dut_div_ff;
   logic signed [16:0] s3_d1m_ff;

   assign s3_off_tc         = $signed({1'b0, offset_tc_ff}) - 17'(OFF_TC_BIAS);
   assign s3_off_prod_in    = s3_off_tc * s2_dut_ff;
   assign s3_sens_prod_in   = $signed({1'b0, sens_tc_ff}) * s2_dut_ff;
   assign s3_tslope_prod_in = $signed({1'b0, temp_slope_ff}) * s2_dut_ff;
   assign s3_dut_div_in     = 28'(trunc_shr(64'(s2_dut_ff), int'(temp_shift)));
   assign s3_d1m_in         = $signed({1'b0, s2_d1_ff}) - 17'(PRESS_ZERO);

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s3_off_prod_ff    <= s3_off_prod_in;
         s3_sens_prod_ff   <= s3_sens_prod_in;
         s3_tslope_prod_ff <= s3_tslope_prod_in;
         s3_dut_div_ff     <= s3_dut_div_in;
         s3_d1m_ff         <= s3_d1m_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: offset, sensitivity, final temperature
   // ---------------------------------------------------------------------
   logic signed [35:0] s4_off_sum;
   logic signed [35:0] s4_off_in;
   logic signed [35:0] s4_sens_in;
   logic signed [31:0] s4_temp_in;
   logic signed [35:0] s4_off_ff;
   logic signed [35:0] s4_sens_ff;
   logic signed [31:0] s4_temp_ff;
   logic signed [16:0] s4_d1m_ff;

   assign s4_off_sum = 36'(trunc_shr(64'(s3_off_prod_ff), OFF_DIV_SHIFT))
                       + $signed({20'd0, offset_base_ff});
   assign s4_off_in  = s4_off_sum <<< 2;
   assign s4_sens_in = 36'(trunc_shr(64'(s3_sens_prod_ff), SENS_DIV_SHIFT))
                       + $signed({20'd0, sens_base_ff});
   assign s4_temp_in = 32'(TEMP_BASE)
                       + 32'(trunc_shr(64'(s3_tslope_prod_ff), TEMP_DIV_SHIFT))
                       - 32'(s3_dut_div_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s4_off_ff  <= s4_off_in;
         s4_sens_ff <= s4_sens_in;
         s4_temp_ff <= s4_temp_in;
         s4_d1m_ff  <= s3_d1m_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: sensitivity times pressure reading
   // ---------------------------------------------------------------------
   logic signed [52:0] s5_prod_in;
   logic signed [52:0] s5_prod_ff;
   logic signed [35:0] s5_off_ff;
   logic signed [31:0] s5_temp_ff;

   assign s5_prod_in = s4_sens_ff * s4_d1m_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s5_prod_ff <= s5_prod_in;
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: scale and remove offset
   // ---------------------------------------------------------------------
   logic signed [39:0] s6_x_in;
   logic signed [39:0] s6_x_ff;
   logic signed [31:0] s6_temp_ff;

   assign s6_x_in = 40'(trunc_shr(64'(s5_prod_ff), X_DIV_SHIFT)) - 40'(s5_off_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         s6_x_ff    <= s6_x_in;
         s6_temp_ff <= s5_temp_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: x*10/32 plus bias into the output register
   // ---------------------------------------------------------------------
   logic signed [43:0] s7_x10;
   logic signed [43:0] s7_press_full;
   logic signed [31:0] rsp_press_ff;
   logic signed [31:0] rsp_temp_ff;

   assign s7_x10        = (44'(s6_x_ff) <<< 3) + (44'(s6_x_ff) <<< 1);
   assign s7_press_full = 44'(trunc_shr(64'(s7_x10), PRESS_DIV_SHIFT))
                          + $signed({28'd0, press_bias_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         rsp_press_ff <= s7_press_full[31:0];
         rsp_temp_ff  <= s6_temp_ff;
      end
   end

   assign rsp_pressure_tenths    = rsp_press_ff;
   assign rsp_temperature_tenths = rsp_temp_ff;

endmodule

>>> src/bptc_checker.sv
// Port-level checks for the barometer compensation block, bound to the top level.
module bptc_checker import bptc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic signed [31:0]    rsp_pressure_tenths,
   input logic signed [31:0]    rsp_temperature_tenths
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressure_tenths)
                                 && $stable(rsp_temperature_tenths))
      else $error("result changed while stalled");

   // input is never held back while the output side can move
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled with room in the pipeline");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // handshakes are always known, and so is a valid result
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid})
      && (!rsp_valid || !$isunknown({rsp_pressure_tenths, rsp_temperature_tenths})))
      else $error("unknown value on handshake or valid result");

endmodule

bind barometer_raw_to_pressure_temperature bptc_checker u_bptc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_pressure_tenths    (rsp_pressure_tenths),
   .rsp_temperature_tenths (rsp_temperature_tenths)
);

>>> verif/barometer_raw_to_pressure_temperature_tb.sv
// Self-checking testbench for the barometer compensation pipeline: directed table, then random.
module barometer_raw_to_pressure_temperature_tb import bptc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 2;
   localparam int RESET_CYCLES    = 5;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_PHASE      = 3;    // phase that opens with the long receiver hold-off
   localparam int HOLD_ITEMS      = 30;   // items offered back to back during that hold-off
   localparam int LONG_HOLD       = 60;   // cycles the receiver holds off
   localparam int WATCHDOG_LIMIT  = 2000; // cycles without progress while work is outstanding
   localparam int MAX_REPORTS     = 10;

   // One compensated reading, as delivered on rsp_
   typedef struct {
      logic signed [31:0] pressure;
      logic signed [31:0] temperature;
   } reading_type;

   // Directed table: register writes interleaved with items
   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type addr;
      logic [31:0]   data;
      logic [15:0]   rp;
      logic [15:0]   rt;
      bit            typed;   // expected reading given literally in the row
      reading_type   lit;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [15:0]           req_raw_pressure;
   logic [15:0]           req_raw_temperature;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [31:0]    rsp_pressure_tenths;
   logic signed [31:0]    rsp_temperature_tenths;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Mirror of the calibration registers, updated at each sampled write
   logic [31:0] cal [0:7];

   reading_type  expected_q [$];
   plan_row_type plan [$];

   // Handshake results of the latest rising edge, read by the drivers at the falling edge
   bit          req_fire;
   bit          rsp_fire;

   // Literal expectation for the item currently offered
   bit          pending_typed;
   reading_type pending_lit;

   bit          req_idle_on   = 1'b1;
   bit          rsp_idle_on   = 1'b1;
   bit          long_hold_req = 1'b0;

   int          fail_count    = 0;
   int          items_sent    = 0;
   int          directed_sent = 0;
   int          checked       = 0;
   int          stuck_cycles  = 0;

   barometer_raw_to_pressure_temperature dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_raw_pressure       (req_raw_pressure),
      .req_raw_temperature    (req_raw_temperature),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_pressure_tenths    (rsp_pressure_tenths),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .csr_wr_en              (csr_wr_en),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Second-order compensation, computed at 64 bits from the mirrored
   // calibration. Divisions truncate toward zero, as SV signed division does.
   // ------------------------------------------------------------------
   function automatic reading_type compensate(input logic [15:0] rp, input logic [15:0] rt);
      longint      d1, d2, t_ref, dev, sq, gain, dtemp, off, sens, x, p, t;
      longint      sb, ob, stc, otc, tsc, pb;
      int          cs, ts;
      reading_type r;
      d1    = longint'(rp);
      d2    = longint'(rt);
      t_ref = longint'(cal[CSR_REF_TEMPERATURE_RAW]);
      sb    = longint'(cal[CSR_SENS_BASE]);
      ob    = longint'(cal[CSR_OFFSET_BASE]);
      stc   = longint'(cal[CSR_SENS_TEMP_COEFF]);
      otc   = longint'(cal[CSR_OFFSET_TEMP_COEFF]);
      tsc   = longint'(cal[CSR_TEMP_SLOPE_COEFF]);
      pb    = longint'(cal[CSR_PRESSURE_BIAS]);
      cs    = int'(cal[CSR_CURVATURE_TERMS][11:8]);   // only low nibble of each shift byte
      ts    = int'(cal[CSR_CURVATURE_TERMS][3:0]);
      // curvature gain picked by the sign of the deviation
      gain  = (d2 >= t_ref) ? longint'(cal[CSR_CURVATURE_TERMS][31:24])
                            : longint'(cal[CSR_CURVATURE_TERMS][23:16]);
      dev   = d2 - t_ref;
      sq    = (dev * dev) >>> 14;
      dtemp = dev - ((sq * gain) >>> cs);
      off   = (ob + ((otc - 1024) * dtemp) / 16384) * 4;
      sens  = sb + (stc * dtemp) / 1024;
      x     = (sens * (d1 - 7168)) / 16384 - off;
      p     = (x * 10) / 32 + pb;
      t     = 250 + (dtemp * tsc) / 65536 - dtemp / (longint'(1) << ts);
      r.pressure    = p[31:0];
      r.temperature = t[31:0];
      return r;
   endfunction

   function automatic void add_write(input csr_index_type addr, input logic [31:0] data);
      plan_row_type row;
      row       = '{kind: ROW_WRITE, addr: CSR_SENS_BASE, default: '0};
      row.addr  = addr;
      row.data  = data;
      plan.push_back(row);
   endfunction

   function automatic void add_item(input logic [15:0] rp, input logic [15:0] rt);
      plan_row_type row;
      row       = '{kind: ROW_ITEM, addr: CSR_SENS_BASE, default: '0};
      row.rp    = rp;
      row.rt    = rt;
      plan.push_back(row);
   endfunction

   function automatic void add_typed(input logic [15:0] rp, input logic [15:0] rt,
                                     input int p, input int t);
      plan_row_type row;
      row                 = '{kind: ROW_ITEM, addr: CSR_SENS_BASE, default: '0};
      row.rp              = rp;
      row.rt              = rt;
      row.typed           = 1'b1;
      row.lit.pressure    = p;
      row.lit.temperature = t;
      plan.push_back(row);
   endfunction

   // Calibration for a random phase: one all-zero set, one all-ones set, else a mix
   function automatic logic [31:0] cal_value(input int phase);
      case (phase)
         1:       return 32'h0000_0000;
         2:       return 32'hFFFF_FFFF;
         default: begin
            case ($urandom_range(0, 5))
               0:       return 32'h0000_0000;
               1:       return 32'hFFFF_FFFF;
               2:       return $urandom_range(0, 4095);
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic flag_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Sampling at the rising edge: register mirror, expectations, checks
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      reading_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;

      if (!reset && csr_wr_en) begin
         // 16-bit registers keep only the low half of the write data
         if (csr_addr == CSR_CURVATURE_TERMS) cal[csr_addr] = csr_wdata;
         else cal[csr_addr] = {16'd0, csr_wdata[15:0]};
      end

      if (req_fire) begin
         if (pending_typed) expected_q.push_back(pending_lit);
         else expected_q.push_back(compensate(req_raw_pressure, req_raw_temperature));
      end

      if (rsp_fire) begin
         if (expected_q.size() == 0) begin
            flag_failure($sformatf("reading P=%0d T=%0d with nothing expected",
                                   rsp_pressure_tenths, rsp_temperature_tenths));
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (rsp_pressure_tenths !== want.pressure)
               flag_failure($sformatf("pressure_tenths expected %0d got %0d",
                                      want.pressure, rsp_pressure_tenths));
            if (rsp_temperature_tenths !== want.temperature)
               flag_failure($sformatf("temperature_tenths expected %0d got %0d",
                                      want.temperature, rsp_temperature_tenths));
         end
      end

      // progress watchdog: only counts while something is outstanding
      if (!reset && (req_valid || expected_q.size() != 0) && !req_fire && !rsp_fire)
         stuck_cycles++;
      else
         stuck_cycles = 0;
   end

   initial begin : watchdog
      wait (stuck_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no handshake for %0d cycles, %0d readings outstanding",
               WATCHDOG_LIMIT, expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            // hold long enough for every stage to fill and req_stall to rise
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks, all entered and left at a falling edge
   // ------------------------------------------------------------------

   // Offer one item and hold it until accepted; valid stays high on return
   task automatic offer_item(input logic [15:0] rp, input logic [15:0] rt,
                             input bit typed, input reading_type lit);
      req_valid           <= 1'b1;
      req_raw_pressure    <= rp;
      req_raw_temperature <= rt;
      pending_typed        = typed;
      pending_lit          = lit;
      do @(negedge clock); while (!req_fire);
      items_sent++;
   endtask

   // Random sender gap; payload is scrambled while invalid
   task automatic maybe_gap();
      int gap;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid           <= 1'b0;
         req_raw_pressure    <= 16'($urandom());
         req_raw_temperature <= 16'($urandom());
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop offering, wait for every reading, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (NUM_STAGES + 4) @(negedge clock);
   endtask

   // One register write; the enable drops again after each write
   task automatic csr_write(input csr_index_type addr, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int           phase;
      int           n;
      int           i;
      logic [15:0]  rp;
      logic [15:0]  rt;
      bit           prev_item;
      reading_type  none;
      plan_row_type row;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      csr_wr_en           = 1'b0;
      csr_addr            = '0;
      csr_wdata           = '0;
      pending_typed       = 1'b0;
      none                = '{default: '0};
      pending_lit         = none;
      for (i = 0; i < 8; i++) cal[i] = '0;

      // Reset calibration is all zero: sensitivity vanishes, so pressure is
      // -off*10/32 with off = trunc(-raw_t/16)*4, and temperature is 250 - raw_t.
      add_typed(16'h0000, 16'h0000, 0, 250);
      add_typed(16'hFFFF, 16'h0000, 0, 250);
      add_typed(16'h0000, 16'hFFFF, 5118, -65285);
      add_typed(16'hFFFF, 16'hFFFF, 5118, -65285);
      add_typed(16'd7168, 16'd16, 1, 234);
      add_typed(16'd1234, 16'd15, 0, 235);

      // Plausible calibration; garbage in the upper half of 16-bit writes
      add_write(CSR_SENS_BASE,           32'hDEAD_5A3C);
      add_write(CSR_OFFSET_BASE,         32'h0000_1E40);
      add_write(CSR_SENS_TEMP_COEFF,     32'h0000_0200);
      add_write(CSR_OFFSET_TEMP_COEFF,   32'hFFFF_0480);
      add_write(CSR_REF_TEMPERATURE_RAW, 32'h0000_7A00);
      add_write(CSR_TEMP_SLOPE_COEFF,    32'h0000_1800);
      add_write(CSR_PRESSURE_BIAS,       32'h0000_0100);
      add_write(CSR_CURVATURE_TERMS,     32'h4030_0604);
      add_item(16'd7168, 16'h7A00);   // at the reference: zero deviation
      add_item(16'd7167, 16'h7A01);   // just above, above-gain
      add_item(16'd7169, 16'h79FF);   // just below, below-gain
      add_item(16'h0000, 16'h0000);
      add_item(16'hFFFF, 16'hFFFF);
      add_item(16'h8000, 16'h0001);

      // Offset coefficient under its bias; shift bytes above fifteen
      add_write(CSR_OFFSET_TEMP_COEFF,   32'h0000_0100);
      add_write(CSR_CURVATURE_TERMS,     32'hFFFF_F31C);
      add_item(16'd30000, 16'h9000);
      add_item(16'd30000, 16'h6000);
      add_item(16'hFFFF, 16'h0000);

      // Every register at its top value: widest intermediates, 32-bit wrap
      for (i = 0; i < 8; i++) add_write(csr_index_type'(i), 32'hFFFF_FFFF);
      add_item(16'h0000, 16'h0000);
      add_item(16'hFFFF, 16'hFFFF);
      add_item(16'h0000, 16'hFFFF);
      add_item(16'hFFFF, 16'h0000);
      add_item(16'd7168, 16'hFFFF);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed table; register writes only once the pipeline has drained
      prev_item = 1'b0;
      foreach (plan[k]) begin
         row = plan[k];
         if (row.kind == ROW_WRITE) begin
            if (prev_item) settle();
            csr_write(row.addr, row.data);
            prev_item = 1'b0;
         end else begin
            offer_item(row.rp, row.rt, row.typed, row.lit);
            directed_sent++;
            maybe_gap();
            prev_item = 1'b1;
         end
      end

      // Random phases, each under a fresh calibration set
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         for (i = 0; i < 8; i++) csr_write(csr_index_type'(i), cal_value(phase));
         if (phase == NUM_PHASES - 1) begin
            // closing stretch with no idling on either side
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         if (phase == HOLD_PHASE) long_hold_req = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 3))
               0: begin
                  rp = 16'($urandom());
                  rt = 16'($urandom());
               end
               1: begin
                  // close to the reference, both signs of deviation
                  rp = 16'($urandom());
                  rt = 16'(cal[CSR_REF_TEMPERATURE_RAW] + $urandom_range(0, 128) - 64);
               end
               2: begin
                  // on the reference or one count either side
                  rp = 16'($urandom());
                  rt = 16'(cal[CSR_REF_TEMPERATURE_RAW] + $urandom_range(0, 2) - 1);
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0:       rp = 16'h0000;
                     1:       rp = 16'hFFFF;
                     2:       rp = 16'd7168;
                     default: rp = 16'($urandom());
                  endcase
                  rt = 16'($urandom());
               end
            endcase
            offer_item(rp, rt, 1'b0, none);
            // back-to-back while the receiver holds off, so the input stalls
            if (!(phase == HOLD_PHASE && n < HOLD_ITEMS)) maybe_gap();
         end
      end

      settle();

      $display("covered %0d items (%0d from the directed table) over %0d calibration sets",
               items_sent, directed_sent, 4 + NUM_PHASES);
      $display("%0d readings compared, %0d failures, %0d readings outstanding",
               checked, fail_count, expected_q.size());
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
